[hw/rtl/key_matrix_hid_report_tracker_defines.svh]
// Assertion macros shared by the key matrix report tracker RTL.
`ifndef KEY_MATRIX_HID_REPORT_TRACKER_DEFINES_SVH
`define KEY_MATRIX_HID_REPORT_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KMT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmt assertion failed");

// Next-cycle implication, checked outside reset.
`define KMT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmt assertion failed");

`endif

[hw/rtl/kmt_pkg.sv]
// Types, constants, keymap and code decoders of the key matrix report tracker.
package kmt_pkg;

  localparam int KEY_ROW_W = 3;
  localparam int KEY_COL_W = 4;
  localparam int CODE_W    = 8;
  localparam int MOD_W     = 8;
  localparam int HIST_W    = 2;
  localparam int OUT_SLOTS = 6;

  localparam int ROWS_DEF    = 5;
  localparam int COLUMNS_DEF = 14;
  localparam int SLOTS_DEF   = 6;

  localparam int MAP_ROWS = 5;
  localparam int MAP_COLS = 14;
  localparam int MAP_KEYS = MAP_ROWS * MAP_COLS;
  localparam int MAP_AW   = $clog2(MAP_KEYS);

  localparam logic [CODE_W-1:0] CODE_NONE     = 8'h00;
  localparam logic [CODE_W-1:0] CODE_LSHIFT   = 8'h66;
  localparam logic [CODE_W-1:0] CODE_RSHIFT   = 8'h67;
  localparam logic [CODE_W-1:0] CODE_LCTRL    = 8'h68;
  localparam logic [CODE_W-1:0] CODE_RCTRL    = 8'h69;
  localparam logic [CODE_W-1:0] CODE_LGUI     = 8'h6A;
  localparam logic [CODE_W-1:0] CODE_RGUI     = 8'h6B;
  localparam logic [CODE_W-1:0] CODE_LALT     = 8'h6C;
  localparam logic [CODE_W-1:0] CODE_RALT     = 8'h6D;
  localparam logic [CODE_W-1:0] CODE_CAPS     = 8'h6E;
  localparam logic [CODE_W-1:0] CODE_BT       = 8'h6F;
  localparam logic [CODE_W-1:0] CODE_APP_A    = 8'hEF;
  localparam logic [CODE_W-1:0] CODE_APP_B    = 8'hF0;

  localparam logic [MOD_W-1:0] MOD_LCTRL  = 8'h01;
  localparam logic [MOD_W-1:0] MOD_LSHIFT = 8'h02;
  localparam logic [MOD_W-1:0] MOD_LALT   = 8'h04;
  localparam logic [MOD_W-1:0] MOD_LGUI   = 8'h08;
  localparam logic [MOD_W-1:0] MOD_RCTRL  = 8'h10;
  localparam logic [MOD_W-1:0] MOD_RSHIFT = 8'h20;
  localparam logic [MOD_W-1:0] MOD_RALT   = 8'h40;
  localparam logic [MOD_W-1:0] MOD_RGUI   = 8'h80;
  localparam logic [MOD_W-1:0] MOD_NONE   = 8'h00;

  localparam logic [CODE_W-1:0] KEYMAP [MAP_KEYS] = '{
    8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E,
    8'h2A,
    8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30,
    8'h31,
    8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h28,
    8'h52,
    8'h66, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'h67, 8'h50,
    8'h51,
    8'h68, 8'h6A, 8'h6C, 8'h00, 8'h00, 8'h2C, 8'h00, 8'h00, 8'h00, 8'h6D, 8'h00, 8'h6B, 8'h69,
    8'h4F
  };

  // Qualified key event handed to the report update logic.
  typedef struct packed {
    logic              fire;
    logic              press;
    logic              release_ev;
    logic [CODE_W-1:0] code;
  } kmt_event_t;

  function automatic logic [CODE_W-1:0] keymap_code(input logic [KEY_ROW_W-1:0] row,
                                                    input logic [KEY_COL_W-1:0] col);
    logic [MAP_AW-1:0] k;
    k = MAP_AW'(32'(row) * MAP_COLS + 32'(col));
    if (32'(row) < MAP_ROWS && 32'(col) < MAP_COLS) begin
      return KEYMAP[k];
    end
    return CODE_NONE;
  endfunction

  function automatic logic [MOD_W-1:0] modifier_mask(input logic [CODE_W-1:0] code);
    logic [MOD_W-1:0] m;
    unique case (code)
      CODE_LSHIFT: m = MOD_LSHIFT;
      CODE_RSHIFT: m = MOD_RSHIFT;
      CODE_LCTRL:  m = MOD_LCTRL;
      CODE_RCTRL:  m = MOD_RCTRL;
      CODE_LGUI:   m = MOD_LGUI;
      CODE_RGUI:   m = MOD_RGUI;
      CODE_LALT:   m = MOD_LALT;
      CODE_RALT:   m = MOD_RALT;
      default:     m = MOD_NONE;
    endcase
    return m;
  endfunction

  function automatic logic is_inert(input logic [CODE_W-1:0] code);
    return code == CODE_NONE || code == CODE_CAPS || code == CODE_BT ||
           code == CODE_APP_A || code == CODE_APP_B;
  endfunction

endpackage

[hw/rtl/kmt_channels.sv]
// Valid/ready channel interfaces for key samples and report words.
interface kmt_in_if;
  import kmt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KEY_ROW_W-1:0] key_row;
  logic [KEY_COL_W-1:0] key_column;
  logic                 level;

  modport source (output valid, output key_row, output key_column, output level,
                  input ready);
  modport sink   (input valid, input key_row, input key_column, input level,
                  output ready);
endinterface

interface kmt_out_if;
  import kmt_pkg::*;
  logic              valid;
  logic              ready;
  logic [MOD_W-1:0]  modifier_bits;
  logic [CODE_W-1:0] slot_one;
  logic [CODE_W-1:0] slot_two;
  logic [CODE_W-1:0] slot_three;
  logic [CODE_W-1:0] slot_four;
  logic [CODE_W-1:0] slot_five;
  logic [CODE_W-1:0] slot_six;
  logic              press_seen;
  logic              release_seen;

  modport source (output valid, output modifier_bits, output slot_one, output slot_two,
                  output slot_three, output slot_four, output slot_five, output slot_six,
                  output press_seen, output release_seen, input ready);
  modport sink   (input valid, input modifier_bits, input slot_one, input slot_two,
                  input slot_three, input slot_four, input slot_five, input slot_six,
                  input press_seen, input release_seen, output ready);
endinterface

[hw/rtl/kmt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kmt_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 70,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/kmt_report.sv]
// Modifier byte and packed report slot state with their update logic.
module kmt_report
  import kmt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kmt_event_t        ev,
  output logic [MOD_W-1:0]  mod_nxt,
  output logic [CODE_W-1:0] slots_nxt [SLOTS]
);

  logic [MOD_W-1:0]  mod_r;
  logic [CODE_W-1:0] slots_r [SLOTS];

  always_comb begin
    logic [MOD_W-1:0]  mask;
    logic              inert;
    logic              present;
    logic              hit;
    logic [SLOTS-1:0]  prev_full;
    logic [CODE_W-1:0] ext [SLOTS+1];
    mask    = modifier_mask(ev.code);
    inert   = is_inert(ev.code);
    present = 1'b0;
    hit     = 1'b0;
    mod_nxt = mod_r;
    for (int i = 0; i < SLOTS; i++) begin
      slots_nxt[i] = slots_r[i];
      ext[i]       = slots_r[i];
      present      = present | (slots_r[i] == ev.code);
    end
    ext[SLOTS] = CODE_NONE;
    prev_full[0] = 1'b1;
    for (int i = 1; i < SLOTS; i++) begin
      prev_full[i] = (ext[i-1] != CODE_NONE);
    end
    if (ev.fire && ev.press) begin
      if (mask != MOD_NONE) begin
        mod_nxt = mod_r | mask;
      end else if (!inert && !present) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slots_r[i] == CODE_NONE && prev_full[i]) begin
            slots_nxt[i] = ev.code;
          end
        end
      end
    end else if (ev.fire && ev.release_ev) begin
      if (mask != MOD_NONE) begin
        mod_nxt = mod_r & ~mask;
      end else if (!inert) begin
        // shift everything from the first match down by one
        for (int i = 0; i < SLOTS; i++) begin
          hit = hit | (slots_r[i] == ev.code);
          if (hit) begin
            slots_nxt[i] = ext[i+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_NONE;
      for (int i = 0; i < SLOTS; i++) begin
        slots_r[i] <= CODE_NONE;
      end
    end else if (ev.fire) begin
      mod_r <= mod_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        slots_r[i] <= slots_nxt[i];
      end
    end
  end

endmodule

[hw/rtl/key_matrix_hid_report_tracker.sv]
// Top level: key matrix sample tracker producing a 6-key HID boot report word.
//
//   channel  dir  payload                                        accepted when
//   in_ch    in   key_row, key_column, level                     valid & ready
//   out_ch   out  modifier_bits, slot_one..six, press/release    valid & ready
//
// One word per cycle sustained while out_ch is ready; each accepted word goes through
// the history RAM read, then the report update into the output register.
// Key history lives in a registered-read RAM with one valid bit per key, so
// reset clears it at once; a back-to-back hit on the same key is bypassed.
// A stall on out_ch holds the word in the update stage and then backs up in_ch.
`include "key_matrix_hid_report_tracker_defines.svh"

module key_matrix_hid_report_tracker
  import kmt_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int SLOTS   = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  kmt_in_if.sink     in_ch,
  kmt_out_if.source  out_ch
);

  localparam int KEYS   = ROWS * COLUMNS;
  localparam int KEY_AW = (KEYS > 1) ? $clog2(KEYS) : 1;

  logic                 in_fire;
  logic                 acc_inrange;
  logic [KEY_AW-1:0]    acc_idx;

  logic                 s1_v_r;
  logic                 s1_fire;
  logic [KEY_AW-1:0]    s1_idx_r;
  logic [KEY_ROW_W-1:0] s1_row_r;
  logic [KEY_COL_W-1:0] s1_col_r;
  logic                 s1_level_r;
  logic                 s1_inrange_r;
  logic                 s1_byp_v_r;
  logic [HIST_W-1:0]    s1_byp_val_r;

  logic [KEYS-1:0]      hist_valid_r;
  logic [HIST_W-1:0]    ram_rd;
  logic [HIST_W-1:0]    hist;
  logic [HIST_W-1:0]    hist_new;
  logic                 wr_en;
  logic                 press;
  logic                 rel;
  kmt_event_t           ev;

  logic [MOD_W-1:0]     mod_nxt;
  logic [CODE_W-1:0]    slots_nxt [SLOTS];
  logic [CODE_W-1:0]    slots_out [OUT_SLOTS];

  logic                 out_v_r;
  logic [MOD_W-1:0]     out_mod_r;
  logic [CODE_W-1:0]    out_slot_r [OUT_SLOTS];
  logic                 out_press_r;
  logic                 out_rel_r;

  // accept stage
  assign s1_fire     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign acc_inrange = (32'(in_ch.key_row) < ROWS) && (32'(in_ch.key_column) < COLUMNS);
  assign acc_idx     = KEY_AW'(32'(in_ch.key_row) * COLUMNS + 32'(in_ch.key_column));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r     <= acc_idx;
      s1_row_r     <= in_ch.key_row;
      s1_col_r     <= in_ch.key_column;
      s1_level_r   <= in_ch.level;
      s1_inrange_r <= acc_inrange;
      s1_byp_v_r   <= wr_en && (s1_idx_r == acc_idx);
      s1_byp_val_r <= hist_new;
    end
  end

  kmt_ram #(
    .WIDTH (HIST_W),
    .DEPTH (KEYS)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_idx_r),
    .wr_data (hist_new),
    .rd_en   (in_fire),
    .rd_addr (acc_idx),
    .rd_data (ram_rd)
  );

  // update stage
  always_comb begin
    if (s1_byp_v_r) begin
      hist = s1_byp_val_r;
    end else if (hist_valid_r[s1_idx_r]) begin
      hist = ram_rd;
    end else begin
      hist = '0;
    end
  end

  assign hist_new = {hist[0], s1_level_r};
  assign wr_en    = s1_fire && s1_inrange_r;
  assign press    = s1_inrange_r && s1_level_r && hist[0] && !hist[1];
  assign rel      = s1_inrange_r && !s1_level_r && !hist[0] && hist[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_valid_r <= '0;
    end else if (wr_en) begin
      hist_valid_r[s1_idx_r] <= 1'b1;
    end
  end

  assign ev.fire       = s1_fire;
  assign ev.press      = press;
  assign ev.release_ev = rel;
  assign ev.code       = keymap_code(s1_row_r, s1_col_r);

  kmt_report #(
    .SLOTS (SLOTS)
  ) u_report (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev        (ev),
    .mod_nxt   (mod_nxt),
    .slots_nxt (slots_nxt)
  );

  for (genvar g = 0; g < OUT_SLOTS; g++) begin : g_out_slot
    if (g < SLOTS) begin : g_used
      assign slots_out[g] = slots_nxt[g];
    end else begin : g_empty
      assign slots_out[g] = CODE_NONE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_mod_r   <= mod_nxt;
      out_press_r <= press;
      out_rel_r   <= rel;
      for (int i = 0; i < OUT_SLOTS; i++) begin
        out_slot_r[i] <= slots_out[i];
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.modifier_bits = out_mod_r;
  assign out_ch.slot_one      = out_slot_r[0];
  assign out_ch.slot_two      = out_slot_r[1];
  assign out_ch.slot_three    = out_slot_r[2];
  assign out_ch.slot_four     = out_slot_r[3];
  assign out_ch.slot_five     = out_slot_r[4];
  assign out_ch.slot_six      = out_slot_r[5];
  assign out_ch.press_seen    = out_press_r;
  assign out_ch.release_seen  = out_rel_r;

  `KMT_ASSERT_NOW(a_flags_exclusive, clk, rst_n, out_v_r, !(out_press_r && out_rel_r))
  `KMT_ASSERT_NOW(a_no_event_off_matrix, clk, rst_n, s1_v_r && !s1_inrange_r, !press && !rel)
  `KMT_ASSERT_NEXT(a_update_lands_in_output, clk, rst_n, s1_fire, out_v_r)
  `KMT_ASSERT_NOW(a_slots_packed, clk, rst_n, out_v_r && out_slot_r[0] == CODE_NONE,
                  out_slot_r[1] == CODE_NONE)
  `KMT_ASSERT_NEXT(a_history_marked, clk, rst_n, wr_en, hist_valid_r[$past(s1_idx_r)])

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the key matrix HID report tracker: directed and random key samples.
module tb;
  import kmt_pkg::*;

  localparam int MATRIX_ROWS  = 5;
  localparam int MATRIX_COLS  = 14;
  localparam int REPORT_SLOTS = 6;
  localparam int KEY_COUNT    = MATRIX_ROWS * MATRIX_COLS;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [0:KEY_COUNT-1][CODE_W-1:0] KEY_CODES = {
    8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
    8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A,
    8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C,
    8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31,
    8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B,
    8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h28, 8'h52,
    8'h66, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11,
    8'h10, 8'h36, 8'h37, 8'h38, 8'h67, 8'h50, 8'h51,
    8'h68, 8'h6A, 8'h6C, 8'h00, 8'h00, 8'h2C, 8'h00,
    8'h00, 8'h00, 8'h6D, 8'h00, 8'h6B, 8'h69, 8'h4F
  };

  typedef struct packed {
    logic [MOD_W-1:0]                  mods;
    logic [OUT_SLOTS-1:0][CODE_W-1:0]  slots;
    logic                              press;
    logic                              rel;
  } hid_report_t;

  logic clk;
  logic rst_n;

  kmt_in_if  in_if ();
  kmt_out_if out_if ();

  key_matrix_hid_report_tracker #(
    .ROWS    (MATRIX_ROWS),
    .COLUMNS (MATRIX_COLS),
    .SLOTS   (REPORT_SLOTS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predicted block state
  logic [HIST_W-1:0] key_hist [KEY_COUNT];
  logic [MOD_W-1:0]  mod_state;
  logic [CODE_W-1:0] slot_state [REPORT_SLOTS];

  hid_report_t report_q [$];

  int mismatch_count  = 0;
  int reports_checked = 0;
  int samples_sent    = 0;
  int press_count     = 0;
  int release_count   = 0;
  int dropped_count   = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int cycle_count     = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, report_q.size());
      $display("tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Updates the predicted state for one accepted sample and queues the expected word.
  task automatic track_sample(input logic [KEY_ROW_W-1:0] r, input logic [KEY_COL_W-1:0] c,
                              input logic lv);
    int                idx;
    int                pos;
    logic [CODE_W-1:0] code;
    logic [MOD_W-1:0]  mask;
    logic              is_press;
    logic              is_rel;
    logic              found;
    hid_report_t       rep;
    is_press = 1'b0;
    is_rel   = 1'b0;
    if (r < MATRIX_ROWS && c < MATRIX_COLS) begin
      idx  = int'(r) * MATRIX_COLS + int'(c);
      code = KEY_CODES[idx];
      case (code)
        CODE_LSHIFT: mask = MOD_LSHIFT;
        CODE_RSHIFT: mask = MOD_RSHIFT;
        CODE_LCTRL:  mask = MOD_LCTRL;
        CODE_RCTRL:  mask = MOD_RCTRL;
        CODE_LGUI:   mask = MOD_LGUI;
        CODE_RGUI:   mask = MOD_RGUI;
        CODE_LALT:   mask = MOD_LALT;
        CODE_RALT:   mask = MOD_RALT;
        default:     mask = MOD_NONE;
      endcase
      found = (code == CODE_NONE || code == CODE_CAPS || code == CODE_BT ||
               code == CODE_APP_A || code == CODE_APP_B);
      if (lv && key_hist[idx] == 2'b01) begin
        is_press = 1'b1;
        press_count++;
        if (mask != MOD_NONE) begin
          mod_state = mod_state | mask;
        end else if (!found) begin
          for (int i = 0; i < REPORT_SLOTS; i++) begin
            if (slot_state[i] == code) found = 1'b1;
          end
          for (int i = 0; i < REPORT_SLOTS; i++) begin
            if (!found && slot_state[i] == CODE_NONE) begin
              slot_state[i] = code;
              found = 1'b1;
            end
          end
          if (!found) dropped_count++;
        end
      end else if (!lv && key_hist[idx] == 2'b10) begin
        is_rel = 1'b1;
        release_count++;
        if (mask != MOD_NONE) begin
          mod_state = mod_state & ~mask;
        end else if (!found) begin
          pos = -1;
          for (int i = 0; i < REPORT_SLOTS; i++) begin
            if (pos < 0 && slot_state[i] == code) pos = i;
          end
          if (pos >= 0) begin
            for (int j = pos + 1; j < REPORT_SLOTS; j++) slot_state[j-1] = slot_state[j];
            slot_state[REPORT_SLOTS-1] = CODE_NONE;
          end
        end
      end
      key_hist[idx] = {key_hist[idx][0], lv};
    end
    rep.mods = mod_state;
    for (int i = 0; i < OUT_SLOTS; i++) begin
      rep.slots[i] = (i < REPORT_SLOTS) ? slot_state[i] : CODE_NONE;
    end
    rep.press = is_press;
    rep.rel   = is_rel;
    report_q.push_back(rep);
  endtask

  task automatic send_sample(input logic [KEY_ROW_W-1:0] r, input logic [KEY_COL_W-1:0] c,
                             input logic lv);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.key_row    <= r;
    in_if.key_column <= c;
    in_if.level      <= lv;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    track_sample(r, c, lv);
    samples_sent++;
  endtask

  // Two equal samples: a press from an open key, a release from a closed one.
  task automatic key_stroke(input logic [KEY_ROW_W-1:0] r, input logic [KEY_COL_W-1:0] c,
                            input logic lv);
    send_sample(r, c, lv);
    send_sample(r, c, lv);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_report
    hid_report_t want;
    hid_report_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.modifier_bits, out_if.slot_six, out_if.slot_five, out_if.slot_four,
             out_if.slot_three, out_if.slot_two, out_if.slot_one, out_if.press_seen,
             out_if.release_seen};
      if (report_q.size() == 0) begin
        $display("%0t: unexpected report word: expected none, got %h", $time, got);
        mismatch_count++;
      end else begin
        want = report_q.pop_front();
        reports_checked++;
        if (got.mods !== want.mods) begin
          $display("%0t: modifier_bits expected %h got %h", $time, want.mods, got.mods);
          mismatch_count++;
        end
        for (int i = 0; i < OUT_SLOTS; i++) begin
          if (got.slots[i] !== want.slots[i]) begin
            $display("%0t: slot %0d expected %h got %h", $time, i + 1, want.slots[i],
                     got.slots[i]);
            mismatch_count++;
          end
        end
        if (got.press !== want.press) begin
          $display("%0t: press_seen expected %b got %b", $time, want.press, got.press);
          mismatch_count++;
        end
        if (got.rel !== want.rel) begin
          $display("%0t: release_seen expected %b got %b", $time, want.rel, got.rel);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_press_release();
    key_stroke(3'd2, 4'd1, 1'b1);
    key_stroke(3'd4, 4'd13, 1'b1);
    key_stroke(3'd2, 4'd1, 1'b0);
  endtask

  task automatic test_modifier_keys();
    key_stroke(3'd4, 4'd11, 1'b1);
    key_stroke(3'd3, 4'd0, 1'b1);
    key_stroke(3'd4, 4'd11, 1'b0);
  endtask

  task automatic test_corner_positions();
    // unassigned key flags a press but leaves the report alone
    key_stroke(3'd4, 4'd3, 1'b1);
    send_sample(3'd7, 4'd15, 1'b1);
    send_sample(3'd5, 4'd0, 1'b1);
    send_sample(3'd0, 4'd14, 1'b1);
    send_sample(3'd0, 4'd15, 1'b0);
    key_stroke(3'd4, 4'd13, 1'b0);
    key_stroke(3'd3, 4'd0, 1'b0);
    key_stroke(3'd4, 4'd3, 1'b0);
  endtask

  // First half mostly presses keys to fill the report, second half mostly releases them.
  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
    int first;
    int k;
    int rel_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first = samples_sent;
    while (samples_sent - first < count) begin
      rel_pct = (samples_sent - first < count / 2) ? 25 : 95;
      if ($urandom_range(99) < 15) begin
        send_sample(3'($urandom_range(7)), 4'($urandom_range(15)), 1'($urandom_range(1)));
      end else begin
        k = $urandom_range(KEY_COUNT - 1);
        if (key_hist[k][0]) begin
          if ($urandom_range(99) < rel_pct) begin
            key_stroke(3'(k / MATRIX_COLS), 4'(k % MATRIX_COLS), 1'b0);
          end
        end else if ($urandom_range(99) >= rel_pct) begin
          key_stroke(3'(k / MATRIX_COLS), 4'(k % MATRIX_COLS), 1'b1);
        end
      end
    end
    hold_until_drained();
  endtask

  task automatic test_random_phases();
    run_random_phase(0, 0, 300);
    run_random_phase(64, 0, 300);
    run_random_phase(0, 64, 300);
    run_random_phase(17, 17, 300);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.key_row    = '0;
    in_if.key_column = '0;
    in_if.level      = 1'b0;
    out_if.ready     = 1'b0;
    foreach (key_hist[i]) key_hist[i] = 2'b00;
    foreach (slot_state[i]) slot_state[i] = CODE_NONE;
    mod_state = MOD_NONE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_press_release();
    test_modifier_keys();
    test_corner_positions();
    hold_until_drained();
    test_random_phases();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d key samples sent, %0d report words checked", samples_sent,
             reports_checked);
    $display("summary: %0d presses, %0d releases, %0d presses dropped on a full report",
             press_count, release_count, dropped_count);
    if (mismatch_count == 0 && report_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/kmt_pkg.sv
hw/rtl/kmt_channels.sv
hw/rtl/kmt_ram.sv
hw/rtl/kmt_report.sv
hw/rtl/key_matrix_hid_report_tracker.sv
sim/tb.sv
